// File: sv/ttf_pkg.sv
// Shared constants and types for the text to font ROM address unit.
package ttf_pkg;

  localparam logic [7:0]  HANZI_LO   = 8'hB0;
  localparam logic [7:0]  HANZI_HI   = 8'hF7;
  localparam logic [7:0]  SYM_LO     = 8'hA1;
  localparam logic [7:0]  SYM_HI     = 8'hA3;
  localparam logic [7:0]  SECOND_MIN = 8'hA1;
  localparam logic [6:0]  CELLS_ROW  = 7'd94;
  localparam logic [12:0] GB_OFFSET  = 13'd846;
  localparam logic [7:0]  ASCII_LO   = 8'h20;
  localparam logic [7:0]  ASCII_END  = 8'h7E;
  localparam logic [23:0] ASCII_BASE = 24'h03CF80;
  localparam logic [8:0]  DISP_W     = 9'd128;
  localparam logic [6:0]  DISP_H     = 7'd64;
  localparam logic [7:0]  WIDE_W     = 8'd16;
  localparam logic [7:0]  NARROW_W   = 8'd8;
  localparam logic [6:0]  GLYPH_H    = 7'd16;

  typedef struct packed {
    logic [7:0] held_lead;
    logic       lead_pending;
    logic [7:0] column;
    logic [5:0] row;
    logic       active;
  } state_t;

  typedef struct packed {
    logic [23:0] rom_address;
    logic        wide_glyph;
    logic [7:0]  glyph_column;
    logic [2:0]  glyph_page;
    logic        fits_display;
  } glyph_t;

endpackage

// File: sv/text_to_font_rom_address_unit.sv
// Top level: text byte stream to font ROM glyph requests.
//
// Input channel (in_*): one text byte per item with its string start marker
// and start position. Output channel (out_*): one glyph request per
// character, none for lead bytes, skipped bytes and the zero terminator.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low.
// An accepted byte is held in the input register; its result is loaded into the
// output register when the byte advances, and is taken from there once out_stall
// is low. Throughput is one byte per cycle while out_stall is low, set by the
// single decode pass between the two registers.
// A stalled result holds in the output register; the byte behind it waits
// in the input register and in_stall rises only while both are occupied.
// Reset clears the text state (no string active, no pending lead byte,
// column and row zero) and empties both registers.
module text_to_font_rom_address_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_string_start,
  input  logic [7:0]  in_start_column,
  input  logic [5:0]  in_start_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_rom_address,
  output logic        out_wide_glyph,
  output logic [7:0]  out_glyph_column,
  output logic [2:0]  out_glyph_page,
  output logic        out_fits_display
);

  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_start_r;
  logic [7:0]      s1_column_r;
  logic [5:0]      s1_row_r;
  ttf_pkg::state_t state_r;
  ttf_pkg::state_t state_nxt;
  logic            emit;
  ttf_pkg::glyph_t glyph;
  ttf_pkg::glyph_t out_r;
  logic            out_valid_r;
  logic            s1_adv;
  logic            in_take;

  ttf_decode u_decode (
    .state        (state_r),
    .text_byte    (s1_byte_r),
    .string_start (s1_start_r),
    .start_column (s1_column_r),
    .start_row    (s1_row_r),
    .state_nxt    (state_nxt),
    .emit         (emit),
    .glyph        (glyph)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (s1_adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r   <= in_text_byte;
      s1_start_r  <= in_string_start;
      s1_column_r <= in_start_column;
      s1_row_r    <= in_start_row;
    end
    if (s1_adv && emit) begin
      out_r <= glyph;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rom_address  = out_r.rom_address;
  assign out_wide_glyph   = out_r.wide_glyph;
  assign out_glyph_column = out_r.glyph_column;
  assign out_glyph_page   = out_r.glyph_page;
  assign out_fits_display = out_r.fits_display;

endmodule

// File: sv/ttf_decode.sv
// Per-byte decode: next text state and the glyph request for one item.
module ttf_decode (
  input  ttf_pkg::state_t state,
  input  logic [7:0]      text_byte,
  input  logic            string_start,
  input  logic [7:0]      start_column,
  input  logic [5:0]      start_row,
  output ttf_pkg::state_t state_nxt,
  output logic            emit,
  output ttf_pkg::glyph_t glyph
);

  logic [7:0]  col;
  logic [5:0]  row;
  logic        active;
  logic        pending;
  logic [6:0]  gb_row;
  logic [12:0] gb_index;
  logic [17:0] gb_addr;
  logic [23:0] ascii_addr;
  logic [7:0]  width;
  logic [8:0]  col_end;
  logic [6:0]  row_end;
  logic        is_lead;

  always_comb begin
    col     = string_start ? start_column : state.column;
    row     = string_start ? start_row : state.row;
    active  = string_start | state.active;
    pending = !string_start & state.lead_pending;

    if (state.held_lead >= ttf_pkg::HANZI_LO) begin
      gb_row = 7'(state.held_lead - ttf_pkg::HANZI_LO);
    end else begin
      gb_row = 7'(state.held_lead - ttf_pkg::SYM_LO);
    end
    gb_index = 13'(gb_row * ttf_pkg::CELLS_ROW) + 13'(text_byte - ttf_pkg::SECOND_MIN)
             + ttf_pkg::GB_OFFSET;
    gb_addr    = {gb_index, 5'd0};
    ascii_addr = ttf_pkg::ASCII_BASE + {12'd0, 8'(text_byte - ttf_pkg::ASCII_LO), 4'd0};

    is_lead = (text_byte inside {[ttf_pkg::HANZI_LO:ttf_pkg::HANZI_HI]}) ||
              (text_byte inside {[ttf_pkg::SYM_LO:ttf_pkg::SYM_HI]});

    state_nxt              = state;
    state_nxt.column       = col;
    state_nxt.row          = row;
    state_nxt.active       = active;
    state_nxt.lead_pending = 1'b0;
    emit                   = 1'b0;
    width                  = ttf_pkg::NARROW_W;
    glyph.rom_address      = ascii_addr;
    glyph.wide_glyph       = 1'b0;

    if (active) begin
      if (pending && text_byte >= ttf_pkg::SECOND_MIN) begin
        emit              = 1'b1;
        width             = ttf_pkg::WIDE_W;
        glyph.rom_address = {6'd0, gb_addr};
        glyph.wide_glyph  = 1'b1;
      end else if (text_byte == 8'd0) begin
        state_nxt.active = 1'b0;
      end else if (is_lead) begin
        state_nxt.held_lead    = text_byte;
        state_nxt.lead_pending = 1'b1;
      end else if (text_byte inside {[ttf_pkg::ASCII_LO:ttf_pkg::ASCII_END - 8'd1]}) begin
        emit = 1'b1;
      end
    end

    col_end = {1'b0, col} + {1'b0, width};
    row_end = {1'b0, row} + ttf_pkg::GLYPH_H;
    glyph.glyph_column = col;
    glyph.glyph_page   = row[5:3];
    glyph.fits_display = (col_end <= ttf_pkg::DISP_W) && (row_end <= ttf_pkg::DISP_H);
    if (emit) begin
      state_nxt.column = col + width;
    end
  end

endmodule

// File: bench/tb_text_to_font_rom_address_unit.sv
// Self-checking testbench for the text to font ROM address unit.
module tb_text_to_font_rom_address_unit;

  typedef struct {
    logic [7:0]      text_byte;
    logic            string_start;
    logic [7:0]      start_column;
    logic [5:0]      start_row;
    bit              typed;
    ttf_pkg::glyph_t glyph;
  } text_row_t;

  localparam int N_ROWS = 26;
  localparam int N_RANDOM = 1050;
  localparam int LONG_HOLD = 80;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_text_byte;
  logic        in_string_start;
  logic [7:0]  in_start_column;
  logic [5:0]  in_start_row;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] out_rom_address;
  logic        out_wide_glyph;
  logic [7:0]  out_glyph_column;
  logic [2:0]  out_glyph_page;
  logic        out_fits_display;

  text_to_font_rom_address_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_text_byte(in_text_byte),
    .in_string_start(in_string_start),
    .in_start_column(in_start_column),
    .in_start_row(in_start_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rom_address(out_rom_address),
    .out_wide_glyph(out_wide_glyph),
    .out_glyph_column(out_glyph_column),
    .out_glyph_page(out_glyph_page),
    .out_fits_display(out_fits_display)
  );

  // predicted text state
  logic [7:0] held_lead;
  logic       lead_waiting;
  logic [7:0] txt_col;
  logic [5:0] txt_row;
  logic       txt_active;

  ttf_pkg::glyph_t pending_glyphs[$];
  text_row_t       dir_rows[N_ROWS];
  int              in_idle_pct;
  int              out_idle_pct;
  bit              long_hold_req;
  int              hold_left;
  int              n_errors;
  int              n_text_items;
  int              n_glyphs;
  int              n_wide;
  int              n_offscreen;
  bit              need_start;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("timeout at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

  function automatic void place_glyph(input int unsigned addr, input logic [7:0] w,
                                      output ttf_pkg::glyph_t g);
    g.rom_address  = addr[23:0];
    g.wide_glyph   = (w == ttf_pkg::WIDE_W);
    g.glyph_column = txt_col;
    g.glyph_page   = txt_row[5:3];
    g.fits_display = (int'(txt_col) + int'(w) <= int'(ttf_pkg::DISP_W)) &&
                     (int'(txt_row) + int'(ttf_pkg::GLYPH_H) <= int'(ttf_pkg::DISP_H));
    txt_col = txt_col + w;
  endfunction

  function automatic bit predict_glyph(input logic [7:0] b, input logic st,
                                       input logic [7:0] col, input logic [5:0] row,
                                       output ttf_pkg::glyph_t g);
    logic [7:0]  lead;
    int unsigned grow;
    int unsigned addr;
    g = '0;
    if (st) begin
      txt_col      = col;
      txt_row      = row;
      txt_active   = 1'b1;
      lead_waiting = 1'b0;
      held_lead    = '0;
    end
    if (!txt_active) return 1'b0;
    if (lead_waiting) begin
      lead         = held_lead;
      lead_waiting = 1'b0;
      held_lead    = '0;
      if (b >= ttf_pkg::SECOND_MIN) begin
        grow = (lead >= ttf_pkg::HANZI_LO) ? int'(lead - ttf_pkg::HANZI_LO)
                                           : int'(lead - ttf_pkg::SYM_LO);
        addr = (grow * int'(ttf_pkg::CELLS_ROW) + int'(b - ttf_pkg::SECOND_MIN) +
                int'(ttf_pkg::GB_OFFSET)) * 32;
        place_glyph(addr, ttf_pkg::WIDE_W, g);
        return 1'b1;
      end
    end
    if (b == 8'h00) begin
      txt_active = 1'b0;
      return 1'b0;
    end
    if ((b >= ttf_pkg::HANZI_LO && b <= ttf_pkg::HANZI_HI) ||
        (b >= ttf_pkg::SYM_LO && b <= ttf_pkg::SYM_HI)) begin
      held_lead    = b;
      lead_waiting = 1'b1;
      return 1'b0;
    end
    if (b >= ttf_pkg::ASCII_LO && b < ttf_pkg::ASCII_END) begin
      addr = int'(ttf_pkg::ASCII_BASE) + int'(b - ttf_pkg::ASCII_LO) * 16;
      place_glyph(addr, ttf_pkg::NARROW_W, g);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic offer_byte(input logic [7:0] b, input logic st, input logic [7:0] col,
                            input logic [5:0] row, input bit typed,
                            input ttf_pkg::glyph_t tg);
    ttf_pkg::glyph_t g;
    bit              has;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_text_byte    = b;
    in_string_start = st;
    in_start_column = col;
    in_start_row    = row;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (st || txt_active) n_text_items++;
    has = predict_glyph(b, st, col, row, g);
    if (typed) pending_glyphs.push_back(tg);
    else if (has) pending_glyphs.push_back(g);
    @(negedge clk);
  endtask

  task automatic offer_random_byte(input logic [7:0] b);
    bit st;
    st = need_start || ($urandom_range(99) < 3);
    need_start = 1'b0;
    offer_byte(b, st, $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(127)),
               6'($urandom_range(63)), 1'b0, '0);
  endtask

  task automatic offer_random_char();
    int k;
    k = $urandom_range(99);
    if (k < 45) begin
      offer_random_byte(8'($urandom_range(8'h7D, 8'h20)));
    end else if (k < 80) begin
      offer_random_byte($urandom_range(3) == 0 ? 8'($urandom_range(8'hA3, 8'hA1))
                                                 : 8'($urandom_range(8'hF7, 8'hB0)));
      offer_random_byte(8'($urandom_range(8'hFF, 8'hA1)));
    end else if (k < 88) begin
      offer_random_byte(8'($urandom_range(8'hF7, 8'hA1)));
      offer_random_byte(8'($urandom_range(8'hA0)));
    end else if (k < 96) begin
      offer_random_byte(8'($urandom_range(255)));
    end else begin
      offer_random_byte(8'h00);
      if ($urandom_range(9) == 0)
        offer_byte(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                   6'($urandom_range(63)), 1'b0, '0);
      need_start = 1'b1;
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD - 1;
      out_stall     = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic void report_field(input string name, input logic [23:0] exp_v,
                                       input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    ttf_pkg::glyph_t g;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_glyphs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h %b %h %h %b", $time,
                 out_rom_address, out_wide_glyph, out_glyph_column, out_glyph_page,
                 out_fits_display);
        n_errors++;
      end else begin
        g = pending_glyphs.pop_front();
        report_field("rom_address", g.rom_address, out_rom_address);
        report_field("wide_glyph", 24'(g.wide_glyph), 24'(out_wide_glyph));
        report_field("glyph_column", 24'(g.glyph_column), 24'(out_glyph_column));
        report_field("glyph_page", 24'(g.glyph_page), 24'(out_glyph_page));
        report_field("fits_display", 24'(g.fits_display), 24'(out_fits_display));
        n_glyphs++;
        if (g.wide_glyph) n_wide++;
        if (!g.fits_display) n_offscreen++;
      end
    end
  end

  initial begin
    int waited;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_text_byte    = '0;
    in_string_start = 1'b0;
    in_start_column = '0;
    in_start_row    = '0;
    out_stall       = 1'b0;
    long_hold_req   = 1'b0;
    hold_left       = 0;
    n_errors        = 0;
    n_text_items    = 0;
    n_glyphs        = 0;
    n_wide          = 0;
    n_offscreen     = 0;
    need_start      = 1'b1;
    held_lead       = '0;
    lead_waiting    = 1'b0;
    txt_col         = '0;
    txt_row         = '0;
    txt_active      = 1'b0;
    in_idle_pct     = 25;
    out_idle_pct    = 77;

    dir_rows = '{
      '{8'h41, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'h20, 1'b1, 8'h00, 6'd0,  1'b1, {24'h03CF80, 1'b0, 8'd0, 3'd0, 1'b1}},
      '{8'h7D, 1'b0, 8'h00, 6'd0,  1'b1, {24'h03D550, 1'b0, 8'd8, 3'd0, 1'b1}},
      '{8'h7E, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'h1F, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'hB0, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'hA1, 1'b0, 8'h00, 6'd0,  1'b1, {24'h0069C0, 1'b1, 8'd16, 3'd0, 1'b1}},
      '{8'hF7, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'hFE, 1'b0, 8'h00, 6'd0,  1'b1, {24'h03B7A0, 1'b1, 8'd32, 3'd0, 1'b1}},
      '{8'hA1, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'hFF, 1'b0, 8'h00, 6'd0,  1'b1, {24'h007580, 1'b1, 8'd48, 3'd0, 1'b1}},
      '{8'hA3, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'h41, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'hB5, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'h00, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'h41, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'hB0, 1'b1, 8'hF8, 6'd63, 1'b0, '0},
      '{8'hB0, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'hA2, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'h41, 1'b1, 8'd120, 6'd48, 1'b1, {24'h03D190, 1'b0, 8'd120, 3'd6, 1'b1}},
      '{8'h41, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'h00, 1'b1, 8'h55, 6'd5,  1'b0, '0},
      '{8'h41, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'hF7, 1'b1, 8'hFF, 6'h2A, 1'b0, '0},
      '{8'hA0, 1'b0, 8'h00, 6'd0,  1'b0, '0},
      '{8'h7F, 1'b1, 8'hAA, 6'h15, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      offer_byte(dir_rows[i].text_byte, dir_rows[i].string_start, dir_rows[i].start_column,
                 dir_rows[i].start_row, dir_rows[i].typed, dir_rows[i].glyph);

    n_text_items = 0;
    need_start   = 1'b1;
    while (n_text_items < N_RANDOM) begin
      if (n_text_items >= 2 * N_RANDOM / 3 && in_idle_pct != 0) begin
        in_idle_pct   = 0;
        out_idle_pct  = 0;
        long_hold_req = 1'b1;
      end else if (n_text_items >= N_RANDOM / 3 && in_idle_pct == 25) begin
        in_idle_pct  = 77;
        out_idle_pct = 25;
      end
      offer_random_char();
    end
    in_valid = 1'b0;

    waited = 0;
    while (pending_glyphs.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_glyphs.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_glyphs.size());
      n_errors++;
    end

    $display("Ran %0d random text bytes after the directed rows: %0d glyphs checked,",
             n_text_items, n_glyphs);
    $display("%0d of them 16x16 and %0d off-screen, under stalls on both sides.",
             n_wide, n_offscreen);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
